>>> sv/svm_pkg.sv
package svm_pkg;

  localparam logic [5:0] OP_LOAD = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_LC   = 6'd2;
  localparam logic [5:0] OP_LI   = 6'd3;
  localparam logic [5:0] OP_SC   = 6'd4;
  localparam logic [5:0] OP_SI   = 6'd5;
  localparam logic [5:0] OP_PUSH = 6'd6;
  localparam logic [5:0] OP_JMP  = 6'd7;
  localparam logic [5:0] OP_JZ   = 6'd8;
  localparam logic [5:0] OP_JNZ  = 6'd9;
  localparam logic [5:0] OP_CALL = 6'd10;
  localparam logic [5:0] OP_ENT  = 6'd11;
  localparam logic [5:0] OP_ADJ  = 6'd12;
  localparam logic [5:0] OP_LEV  = 6'd13;
  localparam logic [5:0] OP_LEA  = 6'd14;
  localparam logic [5:0] OP_OR   = 6'd15;
  localparam logic [5:0] OP_XOR  = 6'd16;
  localparam logic [5:0] OP_AND  = 6'd17;
  localparam logic [5:0] OP_EQ   = 6'd18;
  localparam logic [5:0] OP_NE   = 6'd19;
  localparam logic [5:0] OP_LT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GT   = 6'd22;
  localparam logic [5:0] OP_GE   = 6'd23;
  localparam logic [5:0] OP_SHL  = 6'd24;
  localparam logic [5:0] OP_SHR  = 6'd25;
  localparam logic [5:0] OP_ADD  = 6'd26;
  localparam logic [5:0] OP_SUB  = 6'd27;
  localparam logic [5:0] OP_MUL  = 6'd28;
  localparam logic [5:0] OP_DIV  = 6'd29;
  localparam logic [5:0] OP_MOD  = 6'd30;
  localparam logic [5:0] OP_EXIT = 6'd31;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DIVZ   = 3'd1;
  localparam logic [2:0] ST_UNSUP  = 3'd2;
  localparam logic [2:0] ST_EXITED = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  typedef struct packed {
    logic [5:0]         command;
    logic signed [31:0] immediate;
    logic [11:0]        preload_address;
  } item_t;

  typedef struct packed {
    logic [31:0]        next_address;
    logic signed [31:0] accumulator;
    logic [2:0]         status;
    logic signed [31:0] exit_value;
  } result_t;

  typedef struct packed {
    logic latch;
    logic issue1;
    logic issue2;
    logic commit;
    logic div_run;
    logic div_finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
    logic out_busy;
  } ctl_stat_t;

endpackage

>>> sv/svm_ctrl.sv
module svm_ctrl
  import svm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        cmd.issue1 = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.issue2 = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        // hold until the previous result transaction is gone
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = stat.div_needed ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/svm_datapath.sv
module svm_datapath
  import svm_pkg::*;
#(
  parameter int MEM_WORDS = 4096
)(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_stall,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  ctl_cmd_t    cmd,
  output ctl_stat_t   stat
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_data;
  logic        rd_ok;

  logic [31:0] start_address;
  logic [11:0] stack_top;
  logic [31:0] acc, pc;
  logic [11:0] sp, fp;
  logic        halted;

  logic [5:0]  op;
  logic [31:0] imm;
  logic [11:0] paddr;
  logic [31:0] d1_q;
  logic        f1_q;

  logic [31:0] quo, rem, dvs;
  logic [4:0]  cnt;
  logic        qneg, rneg, is_mod;

  logic        hlt, is_alu, use1, use2;
  logic [31:0] d1_now, a1, a2, rd_addr, d2;
  logic        f2;
  logic [31:0] sp32, fp32, pc1, pc2;

  logic [31:0] acc_next, pc_next, exit_next;
  logic [11:0] sp_next, fp_next;
  logic        halt_next, we, div_start;
  logic [31:0] waddr, wdata;
  logic [2:0]  st_next;
  logic        w_ok;
  logic [31:0] rem_t, quo_fin, rem_fin;
  logic        ge;

  assign sp32 = {20'd0, sp};
  assign fp32 = {20'd0, fp};
  assign pc1  = pc + 32'd1;
  assign pc2  = pc + 32'd2;

  assign hlt    = halted && (op != OP_LOAD);
  assign is_alu = (op >= OP_OR) && (op <= OP_MOD);
  assign use1   = hlt || is_alu || op == OP_LC || op == OP_LI || op == OP_SC
                  || op == OP_SI || op == OP_LEV || op == OP_EXIT;
  assign use2   = !hlt && (op == OP_SC || op == OP_LEV);

  always_comb begin
    if (hlt) a1 = sp32;
    else if (op == OP_LC || op == OP_LI) a1 = acc;
    else if (op == OP_LEV) a1 = fp32;
    else a1 = sp32;
  end

  assign d1_now  = rd_ok ? rd_data : 32'd0;
  assign a2      = (op == OP_SC) ? (cmd.issue2 ? d1_now : d1_q) : {20'd0, fp + 12'd1};
  assign rd_addr = cmd.issue1 ? a1 : a2;
  assign d2      = rd_ok ? rd_data : 32'd0;
  assign f2      = use2 && !rd_ok;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr[AW-1:0]];
    rd_ok   <= rd_addr < MEM_LIMIT;
    if (cmd.commit && we && w_ok) mem[waddr[AW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op    <= item.command;
      imm   <= item.immediate;
      paddr <= item.preload_address;
    end
    if (cmd.issue2) begin
      d1_q <= d1_now;
      f1_q <= use1 && !rd_ok;
    end
  end

  // execution of the latched instruction
  always_comb begin
    acc_next  = acc;
    pc_next   = pc;
    sp_next   = sp;
    fp_next   = fp;
    halt_next = halted;
    exit_next = 32'd0;
    we        = 1'b0;
    waddr     = {20'd0, sp - 12'd1};
    wdata     = acc;
    st_next   = ST_OK;
    div_start = 1'b0;
    if (op == OP_LOAD) begin
      we    = 1'b1;
      waddr = {20'd0, paddr};
      wdata = imm;
    end else if (hlt) begin
      st_next   = ST_EXITED;
      exit_next = d1_q;
    end else if (is_alu) begin
      sp_next = sp + 12'd1;
      pc_next = pc1;
      case (op)
        OP_OR:  acc_next = d1_q | acc;
        OP_XOR: acc_next = d1_q ^ acc;
        OP_AND: acc_next = d1_q & acc;
        OP_EQ:  acc_next = {31'd0, d1_q == acc};
        OP_NE:  acc_next = {31'd0, d1_q != acc};
        OP_LT:  acc_next = {31'd0, $signed(d1_q) <  $signed(acc)};
        OP_LE:  acc_next = {31'd0, $signed(d1_q) <= $signed(acc)};
        OP_GT:  acc_next = {31'd0, $signed(d1_q) >  $signed(acc)};
        OP_GE:  acc_next = {31'd0, $signed(d1_q) >= $signed(acc)};
        OP_SHL: acc_next = d1_q << acc[4:0];
        OP_SHR: acc_next = $unsigned($signed(d1_q) >>> acc[4:0]);
        OP_ADD: acc_next = d1_q + acc;
        OP_SUB: acc_next = d1_q - acc;
        OP_MUL: acc_next = d1_q * acc;
        default: begin
          if (acc == 32'd0) st_next = ST_DIVZ;
          else div_start = 1'b1;
        end
      endcase
    end else begin
      case (op)
        OP_IMM: begin acc_next = imm; pc_next = pc2; end
        OP_LC:  begin acc_next = {{24{d1_q[7]}}, d1_q[7:0]}; pc_next = pc1; end
        OP_LI:  begin acc_next = d1_q; pc_next = pc1; end
        OP_SC: begin
          sp_next  = sp + 12'd1;
          we       = 1'b1;
          waddr    = d1_q;
          wdata    = {d2[31:8], acc[7:0]};
          acc_next = {{24{acc[7]}}, acc[7:0]};
          pc_next  = pc1;
        end
        OP_SI: begin
          sp_next = sp + 12'd1;
          we      = 1'b1;
          waddr   = d1_q;
          pc_next = pc1;
        end
        OP_PUSH: begin sp_next = sp - 12'd1; we = 1'b1; pc_next = pc1; end
        OP_JMP:  pc_next = imm;
        OP_JZ:   pc_next = (acc == 32'd0) ? imm : pc2;
        OP_JNZ:  pc_next = (acc != 32'd0) ? imm : pc2;
        OP_CALL: begin sp_next = sp - 12'd1; we = 1'b1; wdata = pc2; pc_next = imm; end
        OP_ENT: begin
          we      = 1'b1;
          wdata   = fp32;
          fp_next = sp - 12'd1;
          sp_next = sp - 12'd1 - imm[11:0];
          pc_next = pc2;
        end
        OP_ADJ: begin sp_next = sp + imm[11:0]; pc_next = pc2; end
        OP_LEV: begin
          fp_next = d1_q[11:0];
          sp_next = fp + 12'd2;
          pc_next = d2;
        end
        OP_LEA: begin acc_next = fp32 + imm; pc_next = pc2; end
        OP_EXIT: begin
          exit_next = d1_q;
          halt_next = 1'b1;
          st_next   = ST_EXITED;
        end
        default: st_next = ST_UNSUP;
      endcase
    end
    w_ok = waddr < MEM_LIMIT;
    if (st_next == ST_OK && (f1_q || f2 || (we && !w_ok))) st_next = ST_RANGE;
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_t   = {rem[30:0], quo[31]};
    ge      = rem_t >= dvs;
    quo_fin = qneg ? (32'd0 - quo) : quo;
    rem_fin = rneg ? (32'd0 - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && div_start) begin
      quo    <= d1_q[31] ? (32'd0 - d1_q) : d1_q;
      dvs    <= acc[31] ? (32'd0 - acc) : acc;
      rem    <= 32'd0;
      cnt    <= 5'd0;
      qneg   <= d1_q[31] ^ acc[31];
      rneg   <= d1_q[31];
      is_mod <= (op == OP_MOD);
    end else if (cmd.div_run) begin
      rem <= ge ? (rem_t - dvs) : rem_t;
      quo <= {quo[30:0], ge};
      cnt <= cnt + 5'd1;
    end
  end

  assign stat.div_needed = div_start;
  assign stat.div_last   = (cnt == 5'd31);
  assign stat.out_busy   = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 32'd0;
      stack_top     <= 12'hFFF;
      acc           <= 32'd0;
      pc            <= 32'd0;
      sp            <= 12'hFFF;
      fp            <= 12'hFFF;
      halted        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_START: begin
            start_address <= cfg_data;
            pc            <= cfg_data;
            halted        <= 1'b0;
          end
          CFG_STACK: begin
            stack_top <= cfg_data[11:0];
            sp        <= cfg_data[11:0];
            fp        <= cfg_data[11:0];
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        acc    <= acc_next;
        pc     <= pc_next;
        sp     <= sp_next;
        fp     <= fp_next;
        halted <= halt_next;
        if (!div_start) result_valid <= 1'b1;
      end
      if (cmd.div_finish) begin
        acc          <= is_mod ? rem_fin : quo_fin;
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.next_address <= pc_next;
      result.accumulator  <= acc_next;
      result.status       <= st_next;
      result.exit_value   <= exit_next;
    end
    if (cmd.div_finish) result.accumulator <= is_mod ? rem_fin : quo_fin;
  end

endmodule

>>> sv/stack_vm_execute_top.sv
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   item_t (command, immediate, preload_address)
// result    out        result_valid / result_stall  result_t
// cfg       in         cfg_write                 cfg_index, cfg_data
//
// an instruction is latched on acceptance, its operands are read through the
// registered data memory port twice in sequence, then it executes and its
// result is registered; the next item is taken once the block is idle again.
// with a nonzero divisor, DIV and MOD wait for the one-bit-per-cycle divider.
// reset is synchronous; data memory content is not cleared.
// a waiting result stalls the next instruction only at its execute step.
module stack_vm_execute_top
  import svm_pkg::*;
#(
  parameter int MEM_WORDS = 4096
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  svm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  svm_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import svm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_START;
  logic [31:0] cfg_data = '0;

  stack_vm_execute_top i_dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall,
    .result, .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // machine shadow state
  logic [31:0] vm_acc, vm_pc, vm_start;
  logic [11:0] vm_sp, vm_fp, vm_stack_top;
  logic        vm_halted, vm_fault;
  logic [31:0] vm_mem [4096];
  bit          vm_written [4096];

  result_t     pending_results [$];
  int          errors = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] mem_rd(input logic [31:0] addr);
    if (addr >= 32'd4096) begin
      vm_fault = 1'b1;
      return '0;
    end
    return vm_mem[addr[11:0]];
  endfunction

  function automatic void mem_wr(input logic [31:0] addr, input logic [31:0] val);
    if (addr >= 32'd4096) vm_fault = 1'b1;
    else begin
      vm_mem[addr[11:0]] = val;
      vm_written[addr[11:0]] = 1'b1;
    end
  endfunction

  function automatic void vm_push(input logic [31:0] val);
    vm_sp = vm_sp - 12'd1;
    mem_wr({20'd0, vm_sp}, val);
  endfunction

  function automatic logic [31:0] vm_pop();
    logic [31:0] v;
    v = mem_rd({20'd0, vm_sp});
    vm_sp = vm_sp + 12'd1;
    return v;
  endfunction

  function automatic logic [31:0] sext8(input logic [31:0] v);
    return {{24{v[7]}}, v[7:0]};
  endfunction

  function automatic result_t execute_step(input item_t it);
    result_t     r;
    logic [31:0] imm, a, b, w, addr;
    logic [2:0]  st;
    logic [31:0] xv;
    longint      q, m;
    imm = it.immediate;
    st = ST_OK;
    xv = '0;
    vm_fault = 1'b0;
    if (it.command == OP_LOAD) begin
      mem_wr({20'd0, it.preload_address}, imm);
    end else if (vm_halted) begin
      st = ST_EXITED;
      xv = mem_rd({20'd0, vm_sp});
    end else if (it.command >= OP_OR && it.command <= OP_MOD) begin
      a = vm_pop();
      b = vm_acc;
      case (it.command)
        OP_OR:  vm_acc = a | b;
        OP_XOR: vm_acc = a ^ b;
        OP_AND: vm_acc = a & b;
        OP_EQ:  vm_acc = {31'd0, a == b};
        OP_NE:  vm_acc = {31'd0, a != b};
        OP_LT:  vm_acc = {31'd0, $signed(a) < $signed(b)};
        OP_LE:  vm_acc = {31'd0, $signed(a) <= $signed(b)};
        OP_GT:  vm_acc = {31'd0, $signed(a) > $signed(b)};
        OP_GE:  vm_acc = {31'd0, $signed(a) >= $signed(b)};
        OP_SHL: vm_acc = a << b[4:0];
        OP_SHR: vm_acc = $signed(a) >>> b[4:0];
        OP_ADD: vm_acc = a + b;
        OP_SUB: vm_acc = a - b;
        OP_MUL: vm_acc = a * b;
        default: begin
          if (b == '0) begin
            st = ST_DIVZ;
          end else begin
            q = longint'($signed(a)) / longint'($signed(b));
            m = longint'($signed(a)) % longint'($signed(b));
            vm_acc = (it.command == OP_DIV) ? q[31:0] : m[31:0];
          end
        end
      endcase
      vm_pc = vm_pc + 32'd1;
    end else begin
      case (it.command)
        OP_IMM: begin vm_acc = imm; vm_pc = vm_pc + 32'd2; end
        OP_LC: begin vm_acc = sext8(mem_rd(vm_acc)); vm_pc = vm_pc + 32'd1; end
        OP_LI: begin vm_acc = mem_rd(vm_acc); vm_pc = vm_pc + 32'd1; end
        OP_SC: begin
          addr = vm_pop();
          w = mem_rd(addr);
          mem_wr(addr, {w[31:8], vm_acc[7:0]});
          vm_acc = sext8(vm_acc);
          vm_pc = vm_pc + 32'd1;
        end
        OP_SI: begin
          addr = vm_pop();
          mem_wr(addr, vm_acc);
          vm_pc = vm_pc + 32'd1;
        end
        OP_PUSH: begin vm_push(vm_acc); vm_pc = vm_pc + 32'd1; end
        OP_JMP: vm_pc = imm;
        OP_JZ:  vm_pc = (vm_acc == '0) ? imm : vm_pc + 32'd2;
        OP_JNZ: vm_pc = (vm_acc != '0) ? imm : vm_pc + 32'd2;
        OP_CALL: begin vm_push(vm_pc + 32'd2); vm_pc = imm; end
        OP_ENT: begin
          vm_push({20'd0, vm_fp});
          vm_fp = vm_sp;
          vm_sp = vm_sp - imm[11:0];
          vm_pc = vm_pc + 32'd2;
        end
        OP_ADJ: begin vm_sp = vm_sp + imm[11:0]; vm_pc = vm_pc + 32'd2; end
        OP_LEV: begin
          vm_sp = vm_fp;
          a = vm_pop();
          vm_fp = a[11:0];
          vm_pc = vm_pop();
        end
        OP_LEA: begin vm_acc = {20'd0, vm_fp} + imm; vm_pc = vm_pc + 32'd2; end
        OP_EXIT: begin
          xv = mem_rd({20'd0, vm_sp});
          vm_halted = 1'b1;
          st = ST_EXITED;
        end
        default: st = ST_UNSUP;
      endcase
    end
    if (vm_fault && st == ST_OK) st = ST_RANGE;
    r.next_address = vm_pc;
    r.accumulator = vm_acc;
    r.status = st;
    r.exit_value = xv;
    return r;
  endfunction

  task automatic put_item(input item_t it);
    while (gaps_on && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(execute_step(it));
    items_sent++;
  endtask

  // preload a word that is about to be read and was never written
  task automatic fill_word(input logic [31:0] addr);
    item_t ld;
    if (addr < 32'd4096 && !vm_written[addr[11:0]]) begin
      ld.command = OP_LOAD;
      ld.immediate = $urandom;
      ld.preload_address = addr[11:0];
      put_item(ld);
    end
  endtask

  task automatic fill_reads(input item_t it);
    if (vm_halted || (it.command >= OP_OR && it.command <= OP_MOD)
        || it.command == OP_SI || it.command == OP_EXIT) begin
      fill_word({20'd0, vm_sp});
    end else if (it.command == OP_LC || it.command == OP_LI) begin
      fill_word(vm_acc);
    end else if (it.command == OP_SC) begin
      fill_word({20'd0, vm_sp});
      fill_word(vm_mem[vm_sp]);
    end else if (it.command == OP_LEV) begin
      fill_word({20'd0, vm_fp});
      fill_word({20'd0, vm_fp + 12'd1});
    end
  endtask

  task automatic send_item(input item_t it);
    if (it.command != OP_LOAD) fill_reads(it);
    put_item(it);
  endtask

  task automatic send_op(input logic [5:0] cmd, input logic [31:0] imm);
    item_t it;
    it.command = cmd;
    it.immediate = imm;
    it.preload_address = 12'($urandom_range(4095));
    send_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_START) begin
      vm_start = val;
      vm_pc = val;
      vm_halted = 1'b0;
    end else begin
      vm_stack_top = val[11:0];
      vm_sp = val[11:0];
      vm_fp = val[11:0];
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    result_t exp_r;
    cycle_count++;
    if (cycle_count > 1000000) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result with no expected transaction");
      end else begin
        exp_r = pending_results.pop_front();
        if (result.next_address !== exp_r.next_address)
          report($sformatf("next_address %h exp %h", result.next_address, exp_r.next_address));
        if (result.accumulator !== exp_r.accumulator)
          report($sformatf("accumulator %h exp %h", result.accumulator, exp_r.accumulator));
        if (result.status !== exp_r.status)
          report($sformatf("status %0d exp %0d", result.status, exp_r.status));
        if (result.exit_value !== exp_r.exit_value)
          report($sformatf("exit_value %h exp %h", result.exit_value, exp_r.exit_value));
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= gaps_on && ($urandom_range(99) < 35);
    end
  end

  task automatic test_preload_memory();
    item_t it;
    gaps_on = 1'b0;
    for (int i = 0; i < 64; i++) begin
      it.command = OP_LOAD;
      it.immediate = $urandom;
      it.preload_address = 12'(4095 - i);
      send_item(it);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_directed_ops();
    send_op(OP_IMM, 32'h8000_0000);
    send_op(OP_PUSH, 0);
    send_op(OP_IMM, 32'hFFFF_FFFF);
    send_op(OP_DIV, 0);            // most negative over minus one
    send_op(OP_PUSH, 0);
    send_op(OP_IMM, 0);
    send_op(OP_MOD, 0);            // modulo by zero
    for (logic [5:0] op = OP_OR; op <= OP_MUL; op++) begin
      send_op(OP_PUSH, 0);
      send_op(OP_IMM, (op == OP_SHR) ? 32'd31 : 32'h7FFF_FFFF);
    end
    for (logic [5:0] op = OP_OR; op <= OP_MUL; op++) send_op(op, 0);
    send_op(OP_IMM, 32'd100);
    send_op(OP_PUSH, 0);
    send_op(OP_IMM, 32'h0000_0080);
    send_op(OP_SC, 0);             // store byte, sign extends
    send_op(OP_IMM, 32'd100);
    send_op(OP_LC, 0);
    send_op(OP_IMM, 32'd5000);
    send_op(OP_LI, 0);             // out of range read
    send_op(OP_PUSH, 0);
    send_op(OP_SI, 0);             // in-range write to address zero
    send_op(OP_JZ, 32'd44);
    send_op(OP_JNZ, 32'd55);
    send_op(OP_JMP, 32'hFFFF_FFFF);
    send_op(OP_CALL, 32'd200);
    send_op(OP_ENT, 32'd3);
    send_op(OP_LEA, 32'hFFFF_FFFE);
    send_op(OP_ADJ, 32'd1);
    send_op(OP_LEV, 0);
    send_op(6'd32, 0);
    send_op(6'd63, 32'h1234);
    send_op(OP_EXIT, 0);
    send_op(OP_ADD, 0);            // halted
    send_op(OP_LOAD, 32'hCAFE_0001);
    drain();
    write_reg(CFG_START, 32'd0);
  endtask

  function automatic item_t random_item();
    item_t it;
    int    pick;
    pick = $urandom_range(99);
    it.preload_address = 12'($urandom_range(4095));
    if (pick < 5) it.command = OP_LOAD;
    else if (pick < 8) it.command = 6'($urandom_range(63, 32));
    else if (pick < 9) it.command = OP_EXIT;
    else it.command = 6'($urandom_range(30, 1));
    pick = $urandom_range(99);
    if (pick < 50) it.immediate = $urandom_range(4095);
    else if (pick < 75) it.immediate = $urandom_range(16) - 8;
    else it.immediate = $urandom;
    return it;
  endfunction

  task automatic test_random_phases();
    logic [31:0] sa;
    logic [11:0] st;
    for (int k = 0; k < 12; k++) begin
      drain();
      case (k)
        0: begin sa = 32'd0; st = 12'd0; end
        1: begin sa = 32'hFFFF_FFFF; st = 12'hFFF; end
        default: begin sa = $urandom; st = 12'($urandom_range(4095)); end
      endcase
      write_reg(CFG_START, sa);
      write_reg(CFG_STACK, {20'd0, st});
      for (int n = 0; n < 100; n++) send_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    drain();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 60; n++) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  initial begin
    vm_acc = '0;
    vm_start = '0;
    vm_pc = '0;
    vm_stack_top = 12'hFFF;
    vm_sp = 12'hFFF;
    vm_fp = 12'hFFF;
    vm_halted = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_preload_memory();
    test_directed_ops();
    test_random_phases();
    test_backpressure();
    drain();
    $display("sent %0d transactions, checked %0d results", items_sent, results_seen);
    $display("covered preload, all opcodes, halt, faults, config extremes, backpressure");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
